### hdl/view_depth_insertion_sorter_macros.svh
// Assertion macros used by the checker of the depth sorter.
// No dependencies; included by the checker file.
`ifndef VIEW_DEPTH_INSERTION_SORTER_MACROS_SVH
`define VIEW_DEPTH_INSERTION_SORTER_MACROS_SVH

// Implication checked in the same cycle.
`define VDIS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Implication checked in the next cycle.
`define VDIS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/vdis_pkg.sv
// Shared constants and types of the view depth insertion sorter.
// No dependencies; imported by every module of the block.
package vdis_pkg;

   localparam int MAX_ENTRIES = 32;
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
   localparam int ID_W        = 16;
   localparam int DEPTH_W     = 32;
   localparam int COEF_W      = 32;
   localparam int POS_W       = 32;
   localparam int PROD_W      = COEF_W + POS_W;
   localparam int REQ_DATA_W  = ID_W + 3 * POS_W;
   localparam int RSP_DATA_W  = ID_W + DEPTH_W;
   localparam int CSR_IDX_W   = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_VIEW_ZX = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VIEW_ZY = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_VIEW_ZZ = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_VIEW_ZT = 3'd3;

   // 1.0 in Q16.16
   localparam logic signed [COEF_W-1:0] VIEW_ZZ_RESET = 32'sd65536;

   typedef struct packed {
      logic signed [COEF_W-1:0] zx;
      logic signed [COEF_W-1:0] zy;
      logic signed [COEF_W-1:0] zz;
      logic signed [COEF_W-1:0] zt;
   } view_row_type;

   typedef struct packed {
      logic                      valid;
      logic [ID_W-1:0]           id;
      logic signed [DEPTH_W-1:0] depth;
   } entry_type;

   typedef struct packed {
      logic                      insert;
      logic                      shift;
      logic [ID_W-1:0]           new_id;
      logic signed [DEPTH_W-1:0] new_depth;
   } cell_ctl_type;

endpackage

### hdl/vdis_depth.sv
// Four-stage pipeline computing view-space depth from a world position.
// Depends on vdis_pkg.
module vdis_depth
   import vdis_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  view_row_type              view,
   input  logic                      in_valid,
   input  logic [ID_W-1:0]           in_id,
   input  logic                      in_last,
   input  logic signed [POS_W-1:0]   pos_x,
   input  logic signed [POS_W-1:0]   pos_y,
   input  logic signed [POS_W-1:0]   pos_z,
   output logic                      out_valid,
   output logic [ID_W-1:0]           out_id,
   output logic                      out_last,
   output logic signed [DEPTH_W-1:0] out_depth
);

   localparam int SUM2_W  = PROD_W + 1;
   localparam int SUM3_W  = PROD_W + 2;
   localparam int SHR_W   = SUM3_W - 16;
   localparam int WIDE_W  = SHR_W + 1;

   logic [3:0] valid_ff, valid_in;

   logic [ID_W-1:0] id1_ff, id2_ff, id3_ff, id4_ff;
   logic            last1_ff, last2_ff, last3_ff, last4_ff;

   logic signed [PROD_W-1:0]  prod_x_ff, prod_y_ff, prod_z_ff;
   logic signed [SUM2_W-1:0]  sum_xy_ff;
   logic signed [PROD_W-1:0]  prod_z2_ff;
   logic signed [SUM3_W-1:0]  total_ff;
   logic signed [DEPTH_W-1:0] depth_ff, depth_in;

   logic signed [SHR_W-1:0]  shifted;
   logic signed [WIDE_W-1:0] wide;

   // floor(total / 65536) + translation, then clamp to 32 bits
   always_comb begin
      shifted = total_ff[SUM3_W-1:16];
      wide    = {shifted[SHR_W-1], shifted} + WIDE_W'(view.zt);
      if (!wide[WIDE_W-1] && (|wide[WIDE_W-2:DEPTH_W-1])) begin
         depth_in = {1'b0, {(DEPTH_W-1){1'b1}}};
      end else if (wide[WIDE_W-1] && !(&wide[WIDE_W-2:DEPTH_W-1])) begin
         depth_in = {1'b1, {(DEPTH_W-1){1'b0}}};
      end else begin
         depth_in = wide[DEPTH_W-1:0];
      end
   end

   assign valid_in = {valid_ff[2:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_x_ff  <= view.zx * pos_x;
      prod_y_ff  <= view.zy * pos_y;
      prod_z_ff  <= view.zz * pos_z;
      id1_ff     <= in_id;
      last1_ff   <= in_last;

      sum_xy_ff  <= {prod_x_ff[PROD_W-1], prod_x_ff} + {prod_y_ff[PROD_W-1], prod_y_ff};
      prod_z2_ff <= prod_z_ff;
      id2_ff     <= id1_ff;
      last2_ff   <= last1_ff;

      total_ff   <= {sum_xy_ff[SUM2_W-1], sum_xy_ff} + SUM3_W'(prod_z2_ff);
      id3_ff     <= id2_ff;
      last3_ff   <= last2_ff;

      depth_ff   <= depth_in;
      id4_ff     <= id3_ff;
      last4_ff   <= last3_ff;
   end

   assign out_valid = valid_ff[3];
   assign out_id    = id4_ff;
   assign out_last  = last4_ff;
   assign out_depth = depth_ff;

endmodule

### hdl/vdis_cell.sv
// One slot of the sorted insertion chain.
// Depends on vdis_pkg.
module vdis_cell
   import vdis_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cell_ctl_type ctl,
   input  entry_type    prev_entry,
   input  logic         prev_keep,
   input  entry_type    next_entry,
   output entry_type    entry,
   output logic         keep
);

   entry_type entry_ff, entry_in;

   // keep: this slot stays put because it is strictly shallower than the new item
   assign keep = entry_ff.valid && (entry_ff.depth < ctl.new_depth);

   always_comb begin
      entry_in = entry_ff;
      if (ctl.insert) begin
         if (keep) begin
            entry_in = entry_ff;
         end else if (prev_keep) begin
            entry_in.valid = 1'b1;
            entry_in.id    = ctl.new_id;
            entry_in.depth = ctl.new_depth;
         end else begin
            entry_in = prev_entry;
         end
      end else if (ctl.shift) begin
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff <= entry_in;
      end
   end

   assign entry = entry_ff;

endmodule

### hdl/view_depth_insertion_sorter.sv
// Top level of the view depth insertion sorter: registers, control, cell chain.
// Depends on vdis_pkg, vdis_depth and vdis_cell.

// Orders object items by view-space depth. Each item's depth is the view
// matrix z row dotted with its position plus the translation, in Q16.16,
// floored and saturated to 32 bits; a four-stage pipeline (three 32x32
// multipliers, two adds, shift/add/clamp) computes it, and the item then
// drops into a chain of MAX_ENTRIES cells that keeps entries sorted
// ascending, a later item going ahead of equal depths. Outside a run's
// emission one item is accepted per cycle; an item passes through the
// depth pipeline to reach the chain. Once an item with req_tlast is
// accepted, req_tready stays low until the last result of that run is in
// the output register: the chain shifts one entry a cycle toward the
// output while rsp_tvalid is low or rsp_tready is high. Items arriving
// with the chain full are dropped and every result of that run carries
// rsp_tuser high. No clearing pass is needed after reset.
module view_depth_insertion_sorter
   import vdis_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // configuration writes
   input  logic                  csr_wen,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [COEF_W-1:0]     csr_wdata,
   // input items
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // object_id, pos_x, pos_y, pos_z
   input  logic                  req_tlast,  // is_last
   // result items
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // sorted_id, sorted_depth
   output logic                  rsp_tlast,  // end_of_run
   output logic [0:0]            rsp_tuser   // overflowed
);

   // ---------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------
   view_row_type view_ff, view_in;

   always_comb begin
      view_in = view_ff;
      if (csr_wen) begin
         unique case (csr_index)
            CSR_VIEW_ZX: view_in.zx = csr_wdata;
            CSR_VIEW_ZY: view_in.zy = csr_wdata;
            CSR_VIEW_ZZ: view_in.zz = csr_wdata;
            CSR_VIEW_ZT: view_in.zt = csr_wdata;
            default:     view_in = view_ff;  // unknown index: drop the write
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         view_ff.zx <= '0;
         view_ff.zy <= '0;
         view_ff.zz <= VIEW_ZZ_RESET;
         view_ff.zt <= '0;
      end else begin
         view_ff <= view_in;
      end
   end

   // ---------------------------------------------------------------
   // Input acceptance and depth pipeline
   // ---------------------------------------------------------------
   logic busy_ff, busy_in;   // a run end is in flight; hold off new items
   logic accept;

   assign req_tready = !busy_ff;
   assign accept     = req_tvalid && req_tready;

   logic                      ins_valid;
   logic [ID_W-1:0]           ins_id;
   logic                      ins_last;
   logic signed [DEPTH_W-1:0] ins_depth;

   vdis_depth u_depth (
      .clock     (clock),
      .reset     (reset),
      .view      (view_ff),
      .in_valid  (accept),
      .in_id     (req_tdata[ID_W-1:0]),
      .in_last   (req_tlast),
      .pos_x     (req_tdata[ID_W+POS_W-1:ID_W]),
      .pos_y     (req_tdata[ID_W+2*POS_W-1:ID_W+POS_W]),
      .pos_z     (req_tdata[ID_W+3*POS_W-1:ID_W+2*POS_W]),
      .out_valid (ins_valid),
      .out_id    (ins_id),
      .out_last  (ins_last),
      .out_depth (ins_depth)
   );

   // ---------------------------------------------------------------
   // Run control
   // ---------------------------------------------------------------
   logic [CNT_W-1:0] count_ff, count_in;
   logic             drop_ff, drop_in;
   logic             emit_ff, emit_in;
   logic             full;
   logic             out_free;
   logic             run_done;
   cell_ctl_type     ctl;

   assign full     = (count_ff == CNT_W'(MAX_ENTRIES));
   assign out_free = !rsp_tvalid || rsp_tready;

   always_comb begin
      ctl.insert    = ins_valid && !full;
      ctl.shift     = emit_ff && out_free;
      ctl.new_id    = ins_id;
      ctl.new_depth = ins_depth;
   end

   // the final entry of the run moves into the output register
   assign run_done = ctl.shift && (count_ff == CNT_W'(1));

   always_comb begin
      count_in = count_ff;
      drop_in  = drop_ff;
      emit_in  = emit_ff;
      busy_in  = busy_ff;
      if (ctl.insert) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctl.shift) begin
         count_in = count_ff - CNT_W'(1);
      end
      // full chain: drop the item, remember it for the run
      if (ins_valid && full) begin
         drop_in = 1'b1;
      end
      if (ins_valid && ins_last) begin
         emit_in = 1'b1;
      end
      if (accept && req_tlast) begin
         busy_in = 1'b1;
      end
      if (run_done) begin
         drop_in = 1'b0;
         emit_in = 1'b0;
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         drop_ff  <= 1'b0;
         emit_ff  <= 1'b0;
         busy_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         drop_ff  <= drop_in;
         emit_ff  <= emit_in;
         busy_ff  <= busy_in;
      end
   end

   // ---------------------------------------------------------------
   // Sorted cell chain; cell 0 holds the shallowest entry
   // ---------------------------------------------------------------
   entry_type cell_entry [MAX_ENTRIES];
   logic      cell_keep  [MAX_ENTRIES];

   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      entry_type prev_entry;
      entry_type next_entry;
      logic      prev_keep;

      if (i == 0) begin : g_head
         assign prev_entry = '0;
         assign prev_keep  = 1'b1;
      end else begin : g_body
         assign prev_entry = cell_entry[i-1];
         assign prev_keep  = cell_keep[i-1];
      end

      if (i == MAX_ENTRIES - 1) begin : g_tail
         assign next_entry = '0;
      end else begin : g_mid
         assign next_entry = cell_entry[i+1];
      end

      vdis_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .prev_entry (prev_entry),
         .prev_keep  (prev_keep),
         .next_entry (next_entry),
         .entry      (cell_entry[i]),
         .keep       (cell_keep[i])
      );
   end

   // ---------------------------------------------------------------
   // Output register
   // ---------------------------------------------------------------
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]           rsp_id_ff;
   logic signed [DEPTH_W-1:0] rsp_depth_ff;
   logic                      rsp_end_ff;
   logic                      rsp_ovf_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctl.shift) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.shift) begin
         rsp_id_ff    <= cell_entry[0].id;
         rsp_depth_ff <= cell_entry[0].depth;
         rsp_end_ff   <= (count_ff == CNT_W'(1));
         rsp_ovf_ff   <= drop_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_depth_ff, rsp_id_ff};
   assign rsp_tlast  = rsp_end_ff;
   assign rsp_tuser  = rsp_ovf_ff;

endmodule

### hdl/vdis_checker.sv
// Port-level checks of the depth sorter, bound to the top level.
// Depends on vdis_pkg and view_depth_insertion_sorter_macros.svh.
`include "view_depth_insertion_sorter_macros.svh"

module vdis_checker
   import vdis_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  req_tlast,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tlast,
   input logic [0:0]            rsp_tuser
);

   // stalled result holds
   `VDIS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser), "stalled result changed")

   // a run end closes the input
   `VDIS_ASSERT_NEXT(a_run_end_blocks, clock, reset, req_tvalid && req_tready && req_tlast, !req_tready, "input open after run end item")

   // no item taken while a run is still being emitted
   `VDIS_ASSERT_SAME(a_emit_blocks, clock, reset, rsp_tvalid && !rsp_tlast, !req_tready, "input open during emission")

   // emission is gapless and the overflow mark is fixed across a run
   `VDIS_ASSERT_NEXT(a_run_gapless, clock, reset, rsp_tvalid && rsp_tready && !rsp_tlast, rsp_tvalid && $stable(rsp_tuser), "gap or overflow change within a run")

endmodule

bind view_depth_insertion_sorter vdis_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);

### tb/view_depth_insertion_sorter_test.sv
// Self-checking testbench for the view depth insertion sorter: directed table, then random runs.
// Depends on vdis_pkg and view_depth_insertion_sorter; predicts every result item in-line.
module view_depth_insertion_sorter_test;
   import vdis_pkg::*;

   // Indexes past the four view registers; writes there must change nothing.
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_UNMAPPED = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_LAST_UNMAPPED  = 3'd7;

   localparam int SUM_W         = 68;     // exact sum of three 64-bit products
   localparam int RANDOM_ITEMS  = 500;
   localparam int PIPE_CYCLES   = 10;     // depth pipeline plus chain entry, with margin
   localparam int DRAIN_CYCLES  = 40;
   localparam int HOLD_PHASE    = 2;
   localparam int HOLD_RUN_LEN  = 40;     // longer than the store, so it fills and drops
   localparam int HOLD_CYCLES   = 300;
   localparam int WATCHDOG_LIMIT = 3000;

   localparam logic signed [SUM_W-1:0] DEPTH_TOP    = 32'sh7FFF_FFFF;
   localparam logic signed [SUM_W-1:0] DEPTH_BOTTOM = 32'sh8000_0000;

   typedef enum {ROW_CSR, ROW_ITEM, ROW_KNOWN} row_kind_type;

   typedef struct {
      row_kind_type         kind;
      logic [CSR_IDX_W-1:0] reg_index;
      logic [COEF_W-1:0]    reg_value;
      logic [ID_W-1:0]      id;
      logic [POS_W-1:0]     px, py, pz;
      logic                 last;
      logic [DEPTH_W-1:0]   depth;      // known rows only
   } stimulus_row_type;

   typedef struct {
      logic [ID_W-1:0]           id;
      logic signed [DEPTH_W-1:0] depth;
   } depth_slot_type;

   typedef struct {
      logic [ID_W-1:0]    id;
      logic [DEPTH_W-1:0] depth;
      logic               run_end;
      logic               dropped;
   } sorted_item_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_wen = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [COEF_W-1:0]     csr_wdata = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // object_id, pos_x, pos_y, pos_z
   logic                  req_tlast = 1'b0; // is_last
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // sorted_id, sorted_depth
   logic                  rsp_tlast;        // end_of_run
   logic [0:0]            rsp_tuser;        // overflowed

   view_depth_insertion_sorter dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Predictor state: our own copy of the view row and of the sorted store.
   logic signed [COEF_W-1:0] coef_x = '0;
   logic signed [COEF_W-1:0] coef_y = '0;
   logic signed [COEF_W-1:0] coef_z = VIEW_ZZ_RESET;
   logic signed [COEF_W-1:0] coef_t = '0;
   depth_slot_type  sorted_slots[$];
   logic            run_dropped = 1'b0;
   sorted_item_type pending_results[$];

   int  failures = 0;
   bit  hold_rsp = 1'b0;   // set by the sender side, cleared by the receiver
   bit  holding  = 1'b0;

   // Dot the z row with the position, floor the Q32.32 sum back to Q16.16,
   // add the translation, clamp to 32 bits.
   function automatic logic signed [DEPTH_W-1:0] view_depth(
      input logic signed [POS_W-1:0] px, py, pz);
      logic signed [SUM_W-1:0] cx, cy, cz, ct, ex, ey, ez, acc;
      cx = coef_x; cy = coef_y; cz = coef_z; ct = coef_t;
      ex = px;     ey = py;     ez = pz;
      acc = ((cx * ex + cy * ey + cz * ez) >>> 16) + ct;
      if (acc > DEPTH_TOP) return DEPTH_TOP[DEPTH_W-1:0];
      if (acc < DEPTH_BOTTOM) return DEPTH_BOTTOM[DEPTH_W-1:0];
      return acc[DEPTH_W-1:0];
   endfunction

   // Insert ahead of every equal-or-deeper entry; on a last item queue the
   // whole store as expected results and empty it.
   function automatic void admit_entry(input logic [ID_W-1:0] id,
                                       input logic [POS_W-1:0] px, py, pz,
                                       input logic last);
      depth_slot_type slot;
      int             at;
      slot.id    = id;
      slot.depth = view_depth(px, py, pz);
      if (sorted_slots.size() >= MAX_ENTRIES) begin
         run_dropped = 1'b1;
      end else begin
         at = 0;
         while (at < sorted_slots.size() && sorted_slots[at].depth < slot.depth) at++;
         sorted_slots.insert(at, slot);
      end
      if (last) begin
         foreach (sorted_slots[i])
            pending_results.push_back('{sorted_slots[i].id, sorted_slots[i].depth,
                                        i == sorted_slots.size() - 1, run_dropped});
         sorted_slots.delete();
         run_dropped = 1'b0;
      end
   endfunction

   // Mostly back-to-back, sometimes a few cycles, rarely a long pause.
   function automatic int unsigned idle_span();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) return 0;
      if (pick < 88) return $urandom_range(1, 3);
      if (pick < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 50);
   endfunction

   function automatic logic [COEF_W-1:0] pick_coef();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return VIEW_ZZ_RESET;
         2: return '0;
         3: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         4: return $urandom_range(0, 'h4_0000) - 'h2_0000;
         default: return $urandom_range(0, 'h400) - 'h200;
      endcase
   endfunction

   // Position styles: full range, a few whole units (many equal depths),
   // extremes, moderate values.
   function automatic logic [POS_W-1:0] pick_pos(input int unsigned style);
      logic [POS_W-1:0] units;
      case (style)
         0: return $urandom;
         1: begin
            units = $urandom_range(0, 4) - 2;
            return units << 16;
         end
         2: case ($urandom_range(0, 4))
               0: return 32'h7FFF_FFFF;
               1: return 32'h8000_0000;
               2: return 32'hFFFF_FFFF;
               3: return 32'h0000_0001;
               default: return '0;
            endcase
         default: return $urandom_range(0, 'h20_0000) - 'h10_0000;
      endcase
   endfunction

   function automatic stimulus_row_type csr_row(input logic [CSR_IDX_W-1:0] index,
                                                input logic [COEF_W-1:0] value);
      return '{ROW_CSR, index, value, '0, '0, '0, '0, 1'b0, '0};
   endfunction

   function automatic stimulus_row_type item_row(input logic [ID_W-1:0] id,
                                                 input logic [POS_W-1:0] px, py, pz,
                                                 input logic last);
      return '{ROW_ITEM, '0, '0, id, px, py, pz, last, '0};
   endfunction

   // A lone last item whose depth can be read straight off the row.
   function automatic stimulus_row_type known_row(input logic [ID_W-1:0] id,
                                                  input logic [POS_W-1:0] px, py, pz,
                                                  input logic [DEPTH_W-1:0] depth);
      return '{ROW_KNOWN, '0, '0, id, px, py, pz, 1'b1, depth};
   endfunction

   // Offer one item and hold it until the block takes it. Returns in the
   // time step of the accepting edge with tvalid still high.
   task automatic offer_item(input logic [ID_W-1:0] id, input logic [POS_W-1:0] px, py, pz,
                             input logic last, input bit steady);
      int unsigned gap;
      gap = steady ? 0 : idle_span();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {pz, py, px, id};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
   endtask

   // Drop tvalid, wait out every expected result, then let the pipe drain.
   task automatic settle_block(input int unsigned extra);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] index, input logic [COEF_W-1:0] value);
      settle_block(PIPE_CYCLES);
      csr_wen   <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen <= 1'b0;
      case (index)
         CSR_VIEW_ZX: coef_x = value;
         CSR_VIEW_ZY: coef_y = value;
         CSR_VIEW_ZZ: coef_z = value;
         CSR_VIEW_ZT: coef_t = value;
         default: ;
      endcase
   endtask

   task automatic send_run(input int unsigned len, input bit steady, inout int unsigned sent);
      int unsigned      style;
      logic [ID_W-1:0]  id;
      logic [POS_W-1:0] px, py, pz;
      style = $urandom_range(0, 3);
      for (int unsigned k = 0; k < len; k++) begin
         id = ID_W'($urandom);
         px = pick_pos(style);
         py = pick_pos(style);
         pz = pick_pos(style);
         offer_item(id, px, py, pz, k == len - 1, steady);
         admit_entry(id, px, py, pz, k == len - 1);
         sent++;
      end
   endtask

   // Mostly short runs, some long ones, a few past the store size.
   function automatic int unsigned pick_run_len();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) return $urandom_range(1, 6);
      if (pick < 85) return $urandom_range(7, 20);
      if (pick < 95) return $urandom_range(21, MAX_ENTRIES);
      return $urandom_range(MAX_ENTRIES + 1, MAX_ENTRIES + 13);
   endfunction

   // Receiver: ready bursts broken by stalls; on request, one long hold-off
   // so the sorter fills and backs up into its input.
   initial begin : rsp_side
      int unsigned span;
      forever begin
         if (hold_rsp) begin
            holding = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
            holding  = 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            span = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                                : $urandom_range(1, 16);
            repeat (span) @(posedge clock);
            span = idle_span();
            if (span != 0) begin
               rsp_tready <= 1'b0;
               repeat (span) @(posedge clock);
            end
         end
      end
   end

   // Compare each accepted result item against the oldest expectation.
   always @(posedge clock) begin : check_results
      sorted_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result item: sorted_id %h sorted_depth %h",
                   rsp_tdata[ID_W-1:0], rsp_tdata[ID_W +: DEPTH_W]);
            failures++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata[ID_W-1:0] !== want.id) begin
               $error("sorted_id: expected %h, got %h", want.id, rsp_tdata[ID_W-1:0]);
               failures++;
            end
            if (rsp_tdata[ID_W +: DEPTH_W] !== want.depth) begin
               $error("sorted_depth: expected %h, got %h", want.depth,
                      rsp_tdata[ID_W +: DEPTH_W]);
               failures++;
            end
            if (rsp_tlast !== want.run_end) begin
               $error("end_of_run: expected %b, got %b", want.run_end, rsp_tlast);
               failures++;
            end
            if (rsp_tuser[0] !== want.dropped) begin
               $error("overflowed: expected %b, got %b", want.dropped, rsp_tuser[0]);
               failures++;
            end
         end
      end
   end

   // Give up when neither channel nor the register port moves for too long.
   int unsigned quiet_cycles = 0;
   always @(posedge clock) begin : watchdog
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wen) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      stimulus_row_type directed_rows[$];
      stimulus_row_type row;
      int unsigned      sent;
      int unsigned      phase;

      // After reset the view row is (0, 0, 1.0, 0): depth equals pos_z.
      directed_rows.push_back(known_row(16'h0000, 'h7FFF_FFFF, 'h8000_0000, 'h0, 'h0));
      directed_rows.push_back(known_row(16'hFFFF, 'h8000_0000, 'h7FFF_FFFF, 'h7FFF_FFFF,
                                        'h7FFF_FFFF));
      directed_rows.push_back(known_row(16'h8001, 'h0, 'h0, 'h8000_0000, 'h8000_0000));
      // Equal depths: each later item lands ahead of the earlier ones.
      directed_rows.push_back(item_row(16'h0010, 'h0, 'h0, 'h0005_0000, 1'b0));
      directed_rows.push_back(item_row(16'h0011, 'h0, 'h0, 'h0003_0000, 1'b0));
      directed_rows.push_back(item_row(16'h0012, 'h0, 'h0, 'h0005_0000, 1'b0));
      directed_rows.push_back(item_row(16'h0013, 'h0, 'h0, 'hFFFF_0000, 1'b0));
      directed_rows.push_back(item_row(16'h0014, 'h0, 'h0, 'h0005_0000, 1'b1));
      // Largest coefficients: clamp high and low.
      directed_rows.push_back(csr_row(CSR_VIEW_ZX, 'h7FFF_FFFF));
      directed_rows.push_back(csr_row(CSR_VIEW_ZY, 'h7FFF_FFFF));
      directed_rows.push_back(csr_row(CSR_VIEW_ZZ, 'h7FFF_FFFF));
      directed_rows.push_back(csr_row(CSR_VIEW_ZT, 'h7FFF_FFFF));
      directed_rows.push_back(known_row(16'h0100, 'h7FFF_FFFF, 'h7FFF_FFFF, 'h7FFF_FFFF,
                                        'h7FFF_FFFF));
      directed_rows.push_back(known_row(16'h0101, 'h8000_0000, 'h8000_0000, 'h8000_0000,
                                        'h8000_0000));
      // Most negative times most negative: the sum needs more than 64 bits.
      directed_rows.push_back(csr_row(CSR_VIEW_ZX, 'h8000_0000));
      directed_rows.push_back(csr_row(CSR_VIEW_ZY, 'h8000_0000));
      directed_rows.push_back(csr_row(CSR_VIEW_ZZ, 'h8000_0000));
      directed_rows.push_back(known_row(16'h0102, 'h8000_0000, 'h8000_0000, 'h8000_0000,
                                        'h7FFF_FFFF));
      // Translation alone at its minimum.
      directed_rows.push_back(csr_row(CSR_VIEW_ZT, 'h8000_0000));
      directed_rows.push_back(known_row(16'h0103, 'h0, 'h0, 'h0, 'h8000_0000));
      // One-LSB coefficient: fractions floor toward minus infinity.
      directed_rows.push_back(csr_row(CSR_VIEW_ZX, 'h0));
      directed_rows.push_back(csr_row(CSR_VIEW_ZY, 'h0));
      directed_rows.push_back(csr_row(CSR_VIEW_ZZ, 'h1));
      directed_rows.push_back(csr_row(CSR_VIEW_ZT, 'h0));
      directed_rows.push_back(known_row(16'h0200, 'h0, 'h0, 'hFFFF_FFFF, 'hFFFF_FFFF));
      directed_rows.push_back(known_row(16'h0201, 'h0, 'h0, 'h0000_FFFF, 'h0));
      // Write past the register file: nothing may change.
      directed_rows.push_back(csr_row(CSR_LAST_UNMAPPED, 'hDEAD_BEEF));
      directed_rows.push_back(known_row(16'h0202, 'h0, 'h0, 'hFFFF_FFFF, 'hFFFF_FFFF));
      // Mixed fractional row with a translation.
      directed_rows.push_back(csr_row(CSR_VIEW_ZX, 'h0001_8000));
      directed_rows.push_back(csr_row(CSR_VIEW_ZY, 'hFFFF_0000));
      directed_rows.push_back(csr_row(CSR_VIEW_ZZ, 'h0000_4000));
      directed_rows.push_back(csr_row(CSR_VIEW_ZT, 'h0010_0000));
      directed_rows.push_back(item_row(16'hA5A5, 'h0002_0000, 'h0003_0000, 'hFFF0_0000, 1'b0));
      directed_rows.push_back(item_row(16'h5A5A, 'h8000_0000, 'h7FFF_FFFF, 'h0000_0001, 1'b0));
      directed_rows.push_back(item_row(16'h1234, 'hFFFF_FFFF, 'h0000_0001, 'h7FFF_FFFF, 1'b1));

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Known rows come only at the start or after a last item, so the store is empty and the
      // single result is the row itself.
      foreach (directed_rows[r]) begin
         row = directed_rows[r];
         case (row.kind)
            ROW_CSR: begin
               write_csr(row.reg_index, row.reg_value);
            end
            ROW_ITEM: begin
               offer_item(row.id, row.px, row.py, row.pz, row.last, 1'b0);
               admit_entry(row.id, row.px, row.py, row.pz, row.last);
            end
            default: begin
               offer_item(row.id, row.px, row.py, row.pz, 1'b1, 1'b0);
               pending_results.push_back('{row.id, row.depth, 1'b1, 1'b0});
            end
         endcase
      end

      // Random phases: new view row, then a few runs, each closed by a last item.
      sent  = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         phase++;
         write_csr(CSR_VIEW_ZX, pick_coef());
         write_csr(CSR_VIEW_ZY, pick_coef());
         write_csr(CSR_VIEW_ZZ, pick_coef());
         write_csr(CSR_VIEW_ZT, pick_coef());
         if ($urandom_range(0, 3) == 0)
            write_csr(CSR_IDX_W'($urandom_range(CSR_FIRST_UNMAPPED, CSR_LAST_UNMAPPED)),
                      $urandom);
         if (phase == HOLD_PHASE) begin
            // Stall the receiver first, then stream past the store size.
            settle_block(PIPE_CYCLES);
            hold_rsp = 1'b1;
            while (!holding) @(posedge clock);
            send_run(HOLD_RUN_LEN, 1'b1, sent);
         end
         repeat ($urandom_range(1, 4))
            send_run(pick_run_len(), $urandom_range(0, 3) == 0, sent);
      end

      settle_block(DRAIN_CYCLES);
      if (failures == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
